FILE: design/cspan_pkg.sv
// ----------------------------------------------------------------------------
// cspan_pkg
// Shared widths, register codes, reset values and types of the circle span
// rasterizer.
// ----------------------------------------------------------------------------
package cspan_pkg;

    // Field widths.
    localparam int ROW_W     = 10;
    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 32;
    localparam int EDGE_W    = 24;
    localparam int RADIUS_W  = 9;
    localparam int DIM_W     = 13;
    localparam int SHADE_W   = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Signed working width for frame coordinates before clipping.
    localparam int SPAN_W = 14;

    // Parameter defaults.
    localparam int DEF_MAX_RADIUS = 512;
    localparam int DEF_FRAC_BITS  = 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE_MAX    = 2'd3;

    // Register reset values.
    localparam int                 RST_RADIUS       = 438;
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd800;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd600;
    localparam logic [SHADE_W-1:0] RST_SHADE_MAX    = 8'd140;

    // Legal span of the clipping width.
    localparam logic [DIM_W-1:0] FW_MIN = 13'd2;
    localparam logic [DIM_W-1:0] FW_MAX = 13'd4096;

    // Configuration as held by the top level; radius and width are stored
    // already saturated.
    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [SHADE_W-1:0]  shade_max;
    } t_cfg;

    // Fields that ride along the root pipeline untouched.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic [COORD_W-1:0]        y;
        logic [COLOR_W-1:0]        color;
    } t_side;

endpackage

FILE: design/cspan_front.sv
// ----------------------------------------------------------------------------
// cspan_front
// Row qualification, frame row computation and the row product
// row * (2r - row) that feeds the root pipeline.
// ----------------------------------------------------------------------------
module cspan_front #(
    parameter int RAD_BITS = 9
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cspan_pkg::t_cfg                      i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [cspan_pkg::ROW_W-1:0]          i_row,
    input  logic signed [cspan_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [cspan_pkg::COORD_W-1:0] i_center_y,
    input  logic [cspan_pkg::COLOR_W-1:0]        i_fill_color,
    output logic                                 o_valid,
    output logic [2*RAD_BITS-1:0]                o_prod,
    output cspan_pkg::t_side                     o_side,
    input  logic                                 i_ready
);
    import cspan_pkg::*;

    localparam int MW = 2*RAD_BITS + 2;

    logic [RAD_BITS-1:0]     rad;
    logic [RAD_BITS:0]       two_r;
    logic signed [SPAN_W-1:0] y;
    logic                    keep;
    logic [RAD_BITS:0]       d_row;
    t_side                   side;
    logic [MW-1:0]           mult;
    logic                    rdy1;
    logic                    rdy2;

    logic                    r_f1_v;
    logic [RAD_BITS:0]       r_f1_row;
    logic [RAD_BITS:0]       r_f1_d;
    t_side                   r_f1_side;
    logic                    r_f2_v;
    logic [2*RAD_BITS-1:0]   r_f2_prod;
    t_side                   r_f2_side;

    always_comb begin
        rad   = i_cfg.radius[RAD_BITS-1:0];
        two_r = {rad, 1'b0};
        y     = $signed(SPAN_W'(i_row)) + SPAN_W'(i_center_y) - $signed(SPAN_W'(rad));
        // A row is kept when it lies inside the circle and inside the frame.
        keep  = (i_row < ROW_W'(two_r)) && !y[SPAN_W-1] &&
                (y[SPAN_W-2:0] < i_cfg.frame_height);
        d_row = two_r - i_row[RAD_BITS:0];
        side.cx    = i_center_x;
        side.y     = y[COORD_W-1:0];
        side.color = i_fill_color;
    end

    assign mult = MW'(r_f1_row) * MW'(r_f1_d);

    assign rdy2    = !r_f2_v || i_ready;
    assign rdy1    = !r_f1_v || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_f1_v <= i_valid && keep;
            end
            if (rdy2) begin
                r_f2_v <= r_f1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_f1_row  <= i_row[RAD_BITS:0];
            r_f1_d    <= d_row;
            r_f1_side <= side;
        end
        if (rdy2) begin
            r_f2_prod <= mult[2*RAD_BITS-1:0];
            r_f2_side <= r_f1_side;
        end
    end

    assign o_valid = r_f2_v;
    assign o_prod  = r_f2_prod;
    assign o_side  = r_f2_side;

endmodule

FILE: design/cspan_sqrt.sv
// ----------------------------------------------------------------------------
// cspan_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cspan_sqrt #(
    parameter int ROOT_W = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  cspan_pkg::t_side      i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output cspan_pkg::t_side      o_side,
    input  logic                  i_ready
);
    import cspan_pkg::*;

    localparam int RAD_W = 2*ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int TRY_W = ROOT_W + 3;

    // Stage inputs and next values.
    logic [REM_W-1:0]  c_rem_in  [ROOT_W];
    logic [ROOT_W-1:0] c_q_in    [ROOT_W];
    logic [RAD_W-1:0]  c_rad_in  [ROOT_W];
    t_side             c_side_in [ROOT_W];
    logic [ROOT_W-1:0] c_v_in;
    logic [TRY_W-1:0]  c_acc     [ROOT_W];
    logic [TRY_W-1:0]  c_trial   [ROOT_W];
    logic [TRY_W-1:0]  c_diff    [ROOT_W];
    logic [ROOT_W-1:0] c_ge;
    logic [ROOT_W:0]   rdy;

    // Stage registers; the last stage keeps only the root and the side fields.
    logic [ROOT_W-1:0] r_v;
    logic [ROOT_W-1:0] r_q    [ROOT_W];
    t_side             r_side [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [RAD_W-1:0]  r_rad  [ROOT_W-1];

    assign rdy[ROOT_W] = i_ready;

    for (genvar k = 0; k < ROOT_W; k++) begin : gen_stage
        if (k == 0) begin : gen_first
            assign c_rem_in[k]  = '0;
            assign c_q_in[k]    = '0;
            assign c_rad_in[k]  = i_rad;
            assign c_side_in[k] = i_side;
            assign c_v_in[k]    = i_valid;
        end else begin : gen_next
            assign c_rem_in[k]  = r_rem[k-1];
            assign c_q_in[k]    = r_q[k-1];
            assign c_rad_in[k]  = r_rad[k-1];
            assign c_side_in[k] = r_side[k-1];
            assign c_v_in[k]    = r_v[k-1];
        end

        // Bring down the next pair of radicand bits and try 4q+1.
        assign c_acc[k]   = {c_rem_in[k], c_rad_in[k][RAD_W-1 -: 2]};
        assign c_trial[k] = {1'b0, c_q_in[k], 2'b01};
        assign c_ge[k]    = c_acc[k] >= c_trial[k];
        assign c_diff[k]  = c_ge[k] ? (c_acc[k] - c_trial[k]) : c_acc[k];

        assign rdy[k] = !r_v[k] || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= c_v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_q[k]    <= {c_q_in[k][ROOT_W-2:0], c_ge[k]};
                r_side[k] <= c_side_in[k];
            end
        end

        if (k < ROOT_W-1) begin : gen_carry
            always_ff @(posedge i_clk) begin
                if (rdy[k]) begin
                    r_rem[k] <= c_diff[k][REM_W-1:0];
                    r_rad[k] <= {c_rad_in[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_q[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: design/cspan_back.sv
// ----------------------------------------------------------------------------
// cspan_back
// Span clipping, edge columns and edge gray, then the output register.
// ----------------------------------------------------------------------------
module cspan_back #(
    parameter int RAD_BITS  = 9,
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cspan_pkg::t_cfg                   i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [RAD_BITS+FRAC_BITS-1:0]     i_root,
    input  cspan_pkg::t_side                  i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cspan_pkg::COORD_W-1:0]     o_span_y,
    output logic [cspan_pkg::COORD_W-1:0]     o_left_edge_x,
    output logic [cspan_pkg::COORD_W-1:0]     o_right_edge_x,
    output logic [cspan_pkg::COLOR_W-1:0]     o_span_color,
    output logic [cspan_pkg::EDGE_W-1:0]      o_edge_pixel
);
    import cspan_pkg::*;

    localparam int ROOT_W = RAD_BITS + FRAC_BITS;
    localparam int PROD_W = FRAC_BITS + SHADE_W + 1;
    localparam logic signed [SPAN_W-1:0] ONE_S = SPAN_W'(1);

    logic [RAD_BITS-1:0]      ih;
    logic [FRAC_BITS-1:0]     frac;
    logic signed [SPAN_W-1:0] cx_ext;
    logic signed [SPAN_W-1:0] ih_ext;
    logic signed [SPAN_W-1:0] wm1;
    logic signed [SPAN_W-1:0] start0;
    logic signed [SPAN_W-1:0] start1;
    logic signed [SPAN_W-1:0] start2;
    logic signed [SPAN_W-1:0] end0;
    logic signed [SPAN_W-1:0] end1;
    logic signed [SPAN_W-1:0] right;
    logic signed [SPAN_W-1:0] left;
    logic [FRAC_BITS:0]       weight;
    logic [PROD_W-1:0]        prod;
    logic                     rdy_b;
    logic                     rdy_o;

    logic                     r_b_v;
    logic [COORD_W-1:0]       r_b_y;
    logic [COORD_W-1:0]       r_b_left;
    logic [COORD_W-1:0]       r_b_right;
    logic [COLOR_W-1:0]       r_b_color;
    logic [PROD_W-1:0]        r_b_prod;
    logic                     r_o_v;
    logic [COORD_W-1:0]       r_o_y;
    logic [COORD_W-1:0]       r_o_left;
    logic [COORD_W-1:0]       r_o_right;
    logic [COLOR_W-1:0]       r_o_color;
    logic [SHADE_W-1:0]       r_o_gray;

    always_comb begin
        ih     = i_root[ROOT_W-1:FRAC_BITS];
        frac   = i_root[FRAC_BITS-1:0];
        cx_ext = SPAN_W'($signed(i_side.cx));
        ih_ext = $signed(SPAN_W'(ih));
        wm1    = $signed(SPAN_W'(i_cfg.frame_width)) - ONE_S;
        start0 = cx_ext - ih_ext;
        end0   = cx_ext + ih_ext;
        // Fill start is held inside 1..W-1; the end only at W-1, so a span
        // wholly left of the frame collapses onto the start column.
        start1 = (start0 < ONE_S) ? ONE_S : start0;
        start2 = (start1 > wm1) ? wm1 : start1;
        end1   = (end0 > wm1) ? wm1 : end0;
        right  = (end1 > start2) ? end1 : start2;
        left   = start2 - ONE_S;
        weight = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
        prod   = PROD_W'(i_cfg.shade_max) * PROD_W'(weight);
    end

    assign rdy_o   = !r_o_v || i_ready;
    assign rdy_b   = !r_b_v || rdy_o;
    assign o_ready = rdy_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (rdy_b) begin
                r_b_v <= i_valid;
            end
            if (rdy_o) begin
                r_o_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_y     <= i_side.y;
            r_b_left  <= left[COORD_W-1:0];
            r_b_right <= right[COORD_W-1:0];
            r_b_color <= i_side.color;
            r_b_prod  <= prod;
        end
        if (rdy_o) begin
            r_o_y     <= r_b_y;
            r_o_left  <= r_b_left;
            r_o_right <= r_b_right;
            r_o_color <= r_b_color;
            r_o_gray  <= r_b_prod[FRAC_BITS +: SHADE_W];
        end
    end

    assign o_valid        = r_o_v;
    assign o_span_y       = r_o_y;
    assign o_left_edge_x  = r_o_left;
    assign o_right_edge_x = r_o_right;
    assign o_span_color   = r_o_color;
    assign o_edge_pixel   = {r_o_gray, r_o_gray, r_o_gray};

endmodule

FILE: design/circle_span_rasterizer_top.sv
// ----------------------------------------------------------------------------
// circle_span_rasterizer_top
// One horizontal span of an antialiased filled circle per scanline row.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ------------------------------
//  in       to block   i_in_valid / o_in_stall    row, center_x, center_y,
//                                                 fill_color
//  out      from block o_out_valid / i_out_stall  span_y, left/right edge x,
//                                                 span_color, edge_pixel
//  cfg      to block   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A new transaction can enter on every clock cycle while o_in_stall is low. The
// pipeline has two front stages, one root pipeline stage per root bit, one
// clipping stage and the output register. Reset is synchronous and clears the
// valid bits and the configuration registers to their documented values. A
// stall on the output holds only the stages that are full; empty stages keep
// filling, so nothing is lost or repeated. Rows outside the circle or the
// frame are accepted and dropped in the first stage.
//
module circle_span_rasterizer_top #(
    parameter int MAX_RADIUS = cspan_pkg::DEF_MAX_RADIUS,
    parameter int FRAC_BITS  = cspan_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [cspan_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cspan_pkg::CFG_W-1:0]          i_cfg_data,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [cspan_pkg::ROW_W-1:0]          i_row,
    input  logic signed [cspan_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [cspan_pkg::COORD_W-1:0] i_center_y,
    input  logic [cspan_pkg::COLOR_W-1:0]        i_fill_color,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [cspan_pkg::COORD_W-1:0]        o_span_y,
    output logic [cspan_pkg::COORD_W-1:0]        o_left_edge_x,
    output logic [cspan_pkg::COORD_W-1:0]        o_right_edge_x,
    output logic [cspan_pkg::COLOR_W-1:0]        o_span_color,
    output logic [cspan_pkg::EDGE_W-1:0]         o_edge_pixel
);
    import cspan_pkg::*;

    // The saturated radius needs at most log2(MAX_RADIUS) bits, and never
    // more than the register itself holds.
    localparam int RB_LOG   = $clog2(MAX_RADIUS);
    localparam int RAD_BITS = (RB_LOG < RADIUS_W) ? RB_LOG : RADIUS_W;
    localparam int ROOT_W   = RAD_BITS + FRAC_BITS;
    localparam int RMAX     = MAX_RADIUS - 1;
    localparam logic [RADIUS_W-1:0] RADIUS_SAT = RADIUS_W'(RMAX);
    localparam logic [RADIUS_W-1:0] RADIUS_RST =
        (RST_RADIUS > RMAX) ? RADIUS_SAT : RADIUS_W'(RST_RADIUS);

    t_cfg                  r_cfg;

    logic                  f_ready;
    logic                  f_valid;
    logic [2*RAD_BITS-1:0] f_prod;
    t_side                 f_side;
    logic                  s_ready;
    logic                  s_valid;
    logic [ROOT_W-1:0]     s_root;
    t_side                 s_side;
    logic                  b_ready;

    // Configuration registers. Radius and width are saturated on the way in
    // so the datapath never has to clamp them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius       <= RADIUS_RST;
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.shade_max    <= RST_SHADE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS: begin
                    r_cfg.radius <= (int'(i_cfg_data[RADIUS_W-1:0]) > RMAX) ?
                                    RADIUS_SAT : i_cfg_data[RADIUS_W-1:0];
                end
                REG_FRAME_WIDTH: begin
                    if (i_cfg_data < FW_MIN) begin
                        r_cfg.frame_width <= FW_MIN;
                    end else if (i_cfg_data > FW_MAX) begin
                        r_cfg.frame_width <= FW_MAX;
                    end else begin
                        r_cfg.frame_width <= i_cfg_data;
                    end
                end
                REG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data;
                end
                REG_SHADE_MAX: begin
                    r_cfg.shade_max <= i_cfg_data[SHADE_W-1:0];
                end
            endcase
        end
    end

    // Row qualification and the row product.
    cspan_front #(
        .RAD_BITS(RAD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (f_ready),
        .i_row        (i_row),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_fill_color (i_fill_color),
        .o_valid      (f_valid),
        .o_prod       (f_prod),
        .o_side       (f_side),
        .i_ready      (s_ready)
    );

    // The half-width in fixed point: the radicand carries the product scaled
    // by two to the power of twice the fraction width.
    cspan_sqrt #(
        .ROOT_W(ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (s_ready),
        .i_rad   ({f_prod, {(2*FRAC_BITS){1'b0}}}),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side),
        .i_ready (b_ready)
    );

    // Clipping, edge shading and the output register.
    cspan_back #(
        .RAD_BITS  (RAD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_valid),
        .o_ready        (b_ready),
        .i_root         (s_root),
        .i_side         (s_side),
        .o_valid        (o_out_valid),
        .i_ready        (!i_out_stall),
        .o_span_y       (o_span_y),
        .o_left_edge_x  (o_left_edge_x),
        .o_right_edge_x (o_right_edge_x),
        .o_span_color   (o_span_color),
        .o_edge_pixel   (o_edge_pixel)
    );

    assign o_in_stall = !f_ready;

endmodule
